// ----- rtl/sdr_stream_deframer_alaw_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the deframer checker
// Clocked, reset-qualified property wrappers.
// ----------------------------------------------------------------------------
`ifndef SDR_STREAM_DEFRAMER_ALAW_DEFINES_SVH
`define SDR_STREAM_DEFRAMER_ALAW_DEFINES_SVH

// generic clocked property, disabled while reset is low
`define SDRDF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// signal holds while a transfer is stalled
`define SDRDF_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

// ----- rtl/sdrdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sdrdf_pkg
// Shared types, constants and the A-law expander for the stream deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdrdf_pkg;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned PosW     = 17;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [PosW-1:0] LenHiPos    = 17'd3;
  localparam logic [PosW-1:0] LenLoPos    = 17'd4;
  localparam logic [PosW-1:0] RssiPos     = 17'd6;
  localparam logic [PosW-1:0] RateFirstPos = 17'd9;
  localparam logic [PosW-1:0] RateLastPos = 17'd12;
  localparam logic [6:0]      AudioHdrMin = 7'd5;
  localparam logic [6:0]      SpecHdrMin  = 7'd13;

  localparam logic [7:0]  RstSpecCode  = 8'd0;
  localparam logic [7:0]  RstAudioCode = 8'd1;
  localparam logic [6:0]  RstSpecHdr   = 7'd15;
  localparam logic [6:0]  RstAudioHdr  = 7'd5;
  localparam logic [15:0] RstMaxSamp   = 16'd4096;

  typedef enum logic [2:0] {
    KIND_AUDIO    = 3'd0,
    KIND_SPECTRUM = 3'd1,
    KIND_RSSI     = 3'd2,
    KIND_RATE     = 3'd3,
    KIND_DISCARD  = 3'd4
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEC_CODE  = 3'd0,
    CFG_AUDIO_CODE = 3'd1,
    CFG_SPEC_HDR   = 3'd2,
    CFG_AUDIO_HDR  = 3'd3,
    CFG_MAX_SAMP   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REM_NONE = 2'd0,
    REM_RSSI = 2'd1,
    REM_RATE = 2'd2
  } rem_e;

  // one classified byte: optional leading result, optional rssi/rate tail
  typedef struct packed {
    logic        has_first;
    kind_e       kind;
    logic        first_last;
    logic        tail;
    logic [7:0]  data;
    logic [7:0]  rssi;
    logic [31:0] rate;
  } op_t;

  function automatic logic [15:0] alaw_decode(input logic [7:0] code);
    logic [7:0]  a;
    logic [15:0] mag;
    a = code ^ 8'h55;
    if (a[6:4] == 3'd0) begin
      mag = {8'd0, a[3:0], 4'b1000};
    end else begin
      mag = ({8'd0, a[3:0], 4'b0000} + 16'h0108) << (a[6:4] - 3'd1);
    end
    alaw_decode = a[7] ? mag : (16'd0 - mag);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sdrdf_front.sv -----
// ----------------------------------------------------------------------------
// sdrdf_front
// Config registers, frame tracking and byte classification.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrdf_front
  import sdrdf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                accept_i,
  input  wire logic [7:0]          byte_i,
  output logic                     push_o,
  output op_t                      op_o
);

  logic [7:0]      spec_code_q, audio_code_q;
  logic [6:0]      spec_hdr_q, audio_hdr_q;
  logic [15:0]     max_samp_q;

  logic            in_frame_q, in_frame_d;
  logic            is_audio_q, is_audio_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     plen_q, plen_d;
  logic [7:0]      rssi_q, rssi_d;
  logic [31:0]     rate_q, rate_d;
  logic [15:0]     kept_q, kept_d;

  logic [15:0]     plen_new;
  logic [7:0]      rssi_new;
  logic [31:0]     rate_new;
  logic [6:0]      hlen;
  logic [PosW-1:0] end_pos;
  logic            at_end, in_payload, keep, last_kept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spec_code_q  <= RstSpecCode;
      audio_code_q <= RstAudioCode;
      spec_hdr_q   <= RstSpecHdr;
      audio_hdr_q  <= RstAudioHdr;
      max_samp_q   <= RstMaxSamp;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SPEC_CODE:  spec_code_q  <= cfg_data_i[7:0];
        CFG_AUDIO_CODE: audio_code_q <= cfg_data_i[7:0];
        CFG_SPEC_HDR:   spec_hdr_q   <= cfg_data_i[6:0];
        CFG_AUDIO_HDR:  audio_hdr_q  <= cfg_data_i[6:0];
        CFG_MAX_SAMP:   max_samp_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign plen_new = (pos_q == LenHiPos) ? {byte_i, plen_q[7:0]} :
                    (pos_q == LenLoPos) ? {plen_q[15:8], byte_i} : plen_q;
  assign rssi_new = (!is_audio_q && pos_q == RssiPos) ? byte_i : rssi_q;
  assign rate_new = (!is_audio_q && pos_q >= RateFirstPos && pos_q <= RateLastPos) ?
                    {rate_q[23:0], byte_i} : rate_q;
  assign hlen = is_audio_q ? ((audio_hdr_q < AudioHdrMin) ? AudioHdrMin : audio_hdr_q)
                           : ((spec_hdr_q < SpecHdrMin) ? SpecHdrMin : spec_hdr_q);
  assign end_pos    = {10'd0, hlen} + {1'b0, plen_new} - 17'd1;
  assign at_end     = (pos_q >= end_pos);
  assign in_payload = (pos_q >= {10'd0, hlen});
  assign keep       = (kept_q < max_samp_q);
  assign last_kept  = at_end || (({1'b0, kept_q} + 17'd1) == {1'b0, max_samp_q});

  always_comb begin
    in_frame_d = in_frame_q;
    is_audio_d = is_audio_q;
    pos_d      = pos_q;
    plen_d     = plen_q;
    rssi_d     = rssi_q;
    rate_d     = rate_q;
    kept_d     = kept_q;
    push_o     = 1'b0;
    op_o       = '0;
    op_o.kind  = KIND_DISCARD;
    op_o.data  = byte_i;
    op_o.rssi  = rssi_new;
    op_o.rate  = rate_new;
    if (accept_i) begin
      if (!in_frame_q) begin
        if (byte_i == spec_code_q || byte_i == audio_code_q) begin
          in_frame_d = 1'b1;
          is_audio_d = (byte_i != spec_code_q);
          pos_d      = 17'd1;
          plen_d     = '0;
          rssi_d     = '0;
          rate_d     = '0;
          kept_d     = '0;
        end else begin
          push_o           = 1'b1;
          op_o.has_first   = 1'b1;
          op_o.first_last  = 1'b1;
        end
      end else begin
        plen_d = plen_new;
        rssi_d = rssi_new;
        rate_d = rate_new;
        if (is_audio_q) begin
          if (in_payload && keep) begin
            push_o          = 1'b1;
            op_o.has_first  = 1'b1;
            op_o.kind       = KIND_AUDIO;
            op_o.first_last = last_kept;
            kept_d          = kept_q + 16'd1;
          end
        end else begin
          op_o.kind      = KIND_SPECTRUM;
          op_o.has_first = in_payload;
          op_o.tail      = at_end;
          push_o         = in_payload || at_end;
        end
        if (at_end) begin
          in_frame_d = 1'b0;
          pos_d      = '0;
        end else begin
          pos_d = pos_q + 17'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      is_audio_q <= 1'b0;
      pos_q      <= '0;
      plen_q     <= '0;
      rssi_q     <= '0;
      rate_q     <= '0;
      kept_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      is_audio_q <= is_audio_d;
      pos_q      <= pos_d;
      plen_q     <= plen_d;
      rssi_q     <= rssi_d;
      rate_q     <= rate_d;
      kept_q     <= kept_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sdrdf_fifo.sv -----
// ----------------------------------------------------------------------------
// sdrdf_fifo
// Small queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrdf_fifo
  import sdrdf_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output op_t       op_o,
  output logic      empty_o
);

  op_t              mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{QPtrW{1'b0}}, push_i} - {{QPtrW{1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sdrdf_back.sv -----
// ----------------------------------------------------------------------------
// sdrdf_back
// Expands queued entries into result transfers, A-law decode, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrdf_back
  import sdrdf_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire op_t    op_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  wire logic   m_axis_tready,
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic        vld_q, vld_d;
  kind_e       kind_q, kind_d;
  logic [15:0] samp_q, samp_d;
  logic [31:0] val_q, val_d;
  logic        last_q, last_d;
  rem_e        rem_q, rem_d;
  logic [7:0]  rssi_q, rssi_d;
  logic [31:0] rate_q, rate_d;
  logic        free;

  assign free          = !vld_q || m_axis_tready;
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {val_q, samp_q};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

  always_comb begin
    vld_d  = vld_q;
    kind_d = kind_q;
    samp_d = samp_q;
    val_d  = val_q;
    last_d = last_q;
    rem_d  = rem_q;
    rssi_d = rssi_q;
    rate_d = rate_q;
    pop_o  = 1'b0;
    if (free) begin
      vld_d = 1'b0;
      case (rem_q)
        REM_RSSI: begin
          vld_d  = 1'b1;
          kind_d = KIND_RSSI;
          samp_d = '0;
          val_d  = {24'd0, rssi_q};
          last_d = 1'b0;
          rem_d  = REM_RATE;
        end
        REM_RATE: begin
          vld_d  = 1'b1;
          kind_d = KIND_RATE;
          samp_d = '0;
          val_d  = rate_q;
          last_d = 1'b1;
          rem_d  = REM_NONE;
        end
        default: begin
          if (!empty_i) begin
            pop_o  = 1'b1;
            vld_d  = 1'b1;
            rssi_d = op_i.rssi;
            rate_d = op_i.rate;
            if (op_i.has_first) begin
              kind_d = op_i.kind;
              last_d = op_i.first_last;
              if (op_i.kind == KIND_AUDIO) begin
                samp_d = alaw_decode(op_i.data);
                val_d  = '0;
              end else begin
                samp_d = '0;
                val_d  = {24'd0, op_i.data};
              end
              rem_d = op_i.tail ? REM_RSSI : REM_NONE;
            end else begin
              kind_d = KIND_RSSI;
              samp_d = '0;
              val_d  = {24'd0, op_i.rssi};
              last_d = 1'b0;
              rem_d  = REM_RATE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      rem_q <= REM_NONE;
    end else begin
      vld_q <= vld_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    samp_q <= samp_d;
    val_q  <= val_d;
    last_q <= last_d;
    rssi_q <= rssi_d;
    rate_q <= rate_d;
  end

endmodule

`default_nettype wire

// ----- rtl/sdr_stream_deframer_alaw.sv -----
// ----------------------------------------------------------------------------
// sdr_stream_deframer_alaw
// Splits a byte stream into spectrum/audio frames, A-law decodes audio.
//
//  channel  dir  handshake                  payload
//  s_axis   in   tvalid/tready              tdata[7:0] in_byte
//  m_axis   out  tvalid/tready              tdata, tuser kind, tlast last
//  cfg      in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One input byte per cycle while the queue is not full; a result reaches m_axis
// through the queue write and then the output register.
// A spectrum frame end emits up to three results, which the back end drains
// in turn; a 4-entry queue absorbs that and output stalls.
// Input stalls only when the queue is full. Reset is asynchronous and
// clears all frame state and restores register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_stream_deframer_alaw
  import sdrdf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,  // [7:0] in_byte
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [47:0]              m_axis_tdata,  // [15:0] audio_sample, [47:16] value
  output logic [2:0]               m_axis_tuser,  // [2:0] kind
  output logic                     m_axis_tlast
);

  logic accept, push, pop, full, empty;
  op_t  op_in, op_out;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sdrdf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .byte_i      (s_axis_tdata),
    .push_o      (push),
    .op_o        (op_in)
  );

  sdrdf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (op_in),
    .full_o  (full),
    .pop_i   (pop),
    .op_o    (op_out),
    .empty_o (empty)
  );

  sdrdf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_out),
    .empty_i       (empty),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/sdrdf_checker.sv -----
// ----------------------------------------------------------------------------
// sdrdf_checker
// Port-level checks on the result stream of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sdr_stream_deframer_alaw_defines.svh"

module sdrdf_checker
  import sdrdf_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  `SDRDF_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tdata, "output data changed while stalled")
  `SDRDF_ASSERT(a_frame_end_last, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser == KIND_DISCARD || m_axis_tuser == KIND_RATE)) |-> m_axis_tlast, "discard or rate without last")
  `SDRDF_ASSERT(a_rssi_then_rate, clk_i, rst_ni, (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_RSSI) |=> (m_axis_tvalid && m_axis_tuser == KIND_RATE), "rssi not followed by rate")
  `SDRDF_ASSERT(a_sample_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != KIND_AUDIO) |-> (m_axis_tdata[15:0] == 16'd0), "sample set on non-audio result")

endmodule

bind sdr_stream_deframer_alaw sdrdf_checker u_sdrdf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sdr_stream_deframer_alaw. Streams directed and
// random frames (spectrum, audio, unknown type bytes, truncated frames)
// under several register settings and stall patterns. A scoreboard class
// predicts every result and checks each output transfer in order.
// ----------------------------------------------------------------------------
module testbench;
  import sdrdf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] sample;
    logic [31:0] value;
    logic        last;
  } deframe_result_t;

  class deframe_scoreboard;
    logic [7:0]      spec_code;
    logic [7:0]      audio_code;
    logic [6:0]      spec_hdr;
    logic [6:0]      audio_hdr;
    logic [15:0]     max_samples;
    bit              in_frame;
    bit              is_audio;
    logic [16:0]     position;
    logic [15:0]     pay_len;
    logic [7:0]      rssi;
    logic [31:0]     rate;
    int unsigned     kept;
    deframe_result_t due_q[$];
    int              errors;

    function new();
      spec_code   = RstSpecCode;
      audio_code  = RstAudioCode;
      spec_hdr    = RstSpecHdr;
      audio_hdr   = RstAudioHdr;
      max_samples = RstMaxSamp;
      in_frame    = 1'b0;
      is_audio    = 1'b0;
      position    = '0;
      pay_len     = '0;
      rssi        = '0;
      rate        = '0;
      kept        = 0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] d);
      case (idx)
        CFG_SPEC_CODE:  spec_code = d[7:0];
        CFG_AUDIO_CODE: audio_code = d[7:0];
        CFG_SPEC_HDR:   spec_hdr = d[6:0];
        CFG_AUDIO_HDR:  audio_hdr = d[6:0];
        CFG_MAX_SAMP:   max_samples = d;
        default: ;
      endcase
    endfunction

    function int unsigned eff_hlen(bit audio);
      if (audio) begin
        return (audio_hdr < AudioHdrMin) ? AudioHdrMin : audio_hdr;
      end
      return (spec_hdr < SpecHdrMin) ? SpecHdrMin : spec_hdr;
    endfunction

    function int unsigned header_len_for(logic [7:0] type_byte);
      return eff_hlen(type_byte != spec_code);
    endfunction

    function logic [15:0] alaw_expand(logic [7:0] code);
      logic [7:0]  t;
      logic [15:0] m;
      t = code ^ 8'h55;
      m = {8'd0, t[3:0], 4'h8};
      if (t[6:4] != 3'd0) begin
        m = ({8'd0, t[3:0], 4'h0} + 16'h0108) << (t[6:4] - 3'd1);
      end
      return t[7] ? m : (16'd0 - m);
    endfunction

    function void push_result(kind_e k, logic [15:0] s, logic [31:0] v, bit l);
      deframe_result_t r;
      r.kind   = k;
      r.sample = s;
      r.value  = v;
      r.last   = l;
      due_q.push_back(r);
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    // one accepted input byte
    function void note_byte(logic [7:0] b);
      int unsigned pos;
      int unsigned hlen;
      int unsigned end_pos;
      bit          at_end;
      if (!in_frame) begin
        if (b == spec_code || b == audio_code) begin
          in_frame = 1'b1;
          is_audio = (b != spec_code);
          position = 17'd1;
          pay_len  = '0;
          rssi     = '0;
          rate     = '0;
          kept     = 0;
        end else begin
          push_result(KIND_DISCARD, 16'd0, {24'd0, b}, 1'b1);
        end
        return;
      end
      pos  = position;
      hlen = eff_hlen(is_audio);
      if (pos == LenHiPos) pay_len[15:8] = b;
      else if (pos == LenLoPos) pay_len[7:0] = b;
      if (!is_audio) begin
        if (pos == RssiPos) rssi = b;
        if (pos >= RateFirstPos && pos <= RateLastPos) rate = {rate[23:0], b};
      end
      end_pos = hlen + pay_len - 1;
      at_end  = (pos >= end_pos);
      if (pos >= hlen) begin
        if (is_audio) begin
          if (kept < max_samples) begin
            push_result(KIND_AUDIO, alaw_expand(b), 32'd0,
                        at_end || (kept + 1 == max_samples));
            kept++;
          end
        end else begin
          push_result(KIND_SPECTRUM, 16'd0, {24'd0, b}, 1'b0);
        end
      end
      if (at_end) begin
        if (!is_audio) begin
          push_result(KIND_RSSI, 16'd0, {24'd0, rssi}, 1'b0);
          push_result(KIND_RATE, 16'd0, rate, 1'b1);
        end
        in_frame = 1'b0;
        position = '0;
      end else begin
        position = pos + 1;
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(kind_e k, logic [15:0] s, logic [31:0] v, logic l);
      deframe_result_t want;
      if (due_q.size() == 0) begin
        report_mismatch("unexpected result, kind", k, 0);
        return;
      end
      want = due_q.pop_front();
      if (k != want.kind) report_mismatch("kind", k, want.kind);
      if (s != want.sample) report_mismatch("audio_sample", s, want.sample);
      if (v != want.value) report_mismatch("value", v, want.value);
      if (l != want.last) report_mismatch("last", l, want.last);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [47:0]         m_axis_tdata;  // [15:0] audio_sample, [47:16] value
  logic [2:0]          m_axis_tuser;  // [2:0] kind
  logic                m_axis_tlast;

  deframe_scoreboard sb;
  int                snd_idle = 34;
  int                rcv_idle = 87;
  int                hold_req = 0;
  int                items_sent = 0;

  sdr_stream_deframer_alaw dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // result sink with random stalls and requested long hold-offs
  initial begin : sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_result(kind_e'(m_axis_tuser), m_axis_tdata[15:0], m_axis_tdata[47:16],
                        m_axis_tlast);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task send_byte(logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b);
    items_sent++;
  endtask

  task write_config(logic [7:0] sc, logic [7:0] ac, logic [6:0] sh, logic [6:0] ah,
                    logic [15:0] mx);
    logic [15:0] vals [5];
    vals[0] = {8'd0, sc};
    vals[1] = {8'd0, ac};
    vals[2] = {9'd0, sh};
    vals[3] = {9'd0, ah};
    vals[4] = mx;
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // closes an open frame, then sends at most nsend bytes of a frame with the
  // given type and length
  task send_frame(logic [7:0] type_byte, logic [15:0] plen, int unsigned nsend);
    int unsigned total;
    logic [7:0]  b;
    while (sb.in_frame) send_byte(8'($urandom));
    total = sb.header_len_for(type_byte) + plen;
    if (nsend > total) nsend = total;
    for (int unsigned i = 0; i < nsend; i++) begin
      if (i == 0) b = type_byte;
      else if (i == LenHiPos) b = plen[15:8];
      else if (i == LenLoPos) b = plen[7:0];
      else b = 8'($urandom);
      send_byte(b);
    end
  endtask

  task random_traffic(int count);
    int          target;
    int unsigned r;
    logic [7:0]  b;
    logic [7:0]  t;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(99);
      t = $urandom_range(1) ? sb.audio_code : sb.spec_code;
      if (r < 10) begin
        do b = 8'($urandom); while (b == sb.spec_code || b == sb.audio_code);
        send_byte(b);
      end else if (r < 20) begin
        send_frame(t, 16'($urandom_range(20)), $urandom_range(5, 30));
      end else begin
        send_frame(t, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 24)),
                   32'hFFFF_FFFF);
      end
    end
  endtask

  // close any open frame, then wait for the block to go idle
  task finish_phase();
    while (sb.in_frame) send_byte(8'($urandom));
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0] sc;
    logic [7:0] ac;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unknown type, empty spectrum frame, audio code extremes
    send_byte(8'hFF);
    send_frame(RstSpecCode, 16'd0, 32'hFFFF_FFFF);
    send_frame(RstAudioCode, 16'd4, RstAudioHdr);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hD5);
    finish_phase();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        snd_idle = 34;
        rcv_idle = 87;
      end else if (ph < 4) begin
        snd_idle = 87;
        rcv_idle = 34;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      do begin
        sc = 8'($urandom);
        ac = 8'($urandom);
      end while (sc == ac);
      case (ph)
        0: write_config(8'd0, 8'd1, 7'd13, 7'd5, 16'd0);
        1: write_config(8'd255, 8'd128, 7'd64, 7'd64, 16'd65535);
        2: write_config(8'hA5, 8'hA5, 7'd7, 7'd2, 16'd3);
        3: write_config(sc, ac, 7'($urandom_range(13, 64)), 7'd3, 16'($urandom_range(1, 12)));
        4: write_config(sc, ac, 7'($urandom_range(13, 64)), 7'($urandom_range(5, 64)),
                        16'($urandom_range(1, 20)));
        default: write_config(RstSpecCode, RstAudioCode, RstSpecHdr, RstAudioHdr,
                              RstMaxSamp);
      endcase
      if (ph == 5) begin
        hold_req++;
        send_frame(RstSpecCode, 16'd40, 32'hFFFF_FFFF);
      end
      random_traffic(35);
      finish_phase();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
